// File: rtl/utp_pkg.sv
package utp_pkg;

  localparam int unsigned CpWidth      = 21;
  localparam int unsigned QueueDepthDef = 2;

  typedef logic [CpWidth-1:0] cp_t;

  // lead byte tags for two, three and four byte sequences
  localparam logic [2:0] Lead2 = 3'b110;
  localparam logic [3:0] Lead3 = 4'b1110;
  localparam logic [4:0] Lead4 = 5'b11110;

  localparam cp_t Replacement = 21'h00FFFD;

  // one input word: a raw text byte and its end-of-text flag
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } text_t;

  // one result word
  typedef struct packed {
    logic       char_valid;
    cp_t        code_point;
    logic       word_start;
    logic       text_end;
  } token_t;

  // decoded word handed from the decoder to the classifier
  typedef struct packed {
    logic done;
    cp_t  cp;
    logic last;
  } entry_t;

endpackage

// File: rtl/utp_front.sv
module utp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  output logic             text_ready,
  input  utp_pkg::text_t   text,
  input  logic             queue_full,
  output logic             push,
  output utp_pkg::entry_t  push_entry
);

  logic [1:0]     bytes_pending;
  logic [1:0]     bytes_pending_next;
  utp_pkg::cp_t   partial_point;
  utp_pkg::cp_t   partial_point_next;
  logic           done;
  utp_pkg::cp_t   cp;
  logic [7:0]     b;
  logic           last;

  assign b          = text.text_byte;
  assign last       = text.last_byte;
  assign text_ready = !queue_full;
  assign push       = text_valid && text_ready;

  always_comb begin
    done               = 1'b0;
    cp                 = '0;
    bytes_pending_next = bytes_pending;
    partial_point_next = partial_point;
    if (bytes_pending != 2'd0) begin
      // continuation: shift in low six bits, top bits unchecked
      partial_point_next = {partial_point[utp_pkg::CpWidth-7:0], b[5:0]};
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending_next == 2'd0 || last) begin
        cp   = partial_point_next;
        done = 1'b1;
      end
    end else if (!b[7]) begin
      cp   = utp_pkg::cp_t'(b);
      done = 1'b1;
    end else if (b[7:5] == utp_pkg::Lead2) begin
      partial_point_next = utp_pkg::cp_t'(b[4:0]);
      bytes_pending_next = 2'd1;
    end else if (b[7:4] == utp_pkg::Lead3) begin
      partial_point_next = utp_pkg::cp_t'(b[3:0]);
      bytes_pending_next = 2'd2;
    end else if (b[7:3] == utp_pkg::Lead4) begin
      partial_point_next = utp_pkg::cp_t'(b[2:0]);
      bytes_pending_next = 2'd3;
    end
    // lead byte as final byte: take what was gathered
    if (!done && last && bytes_pending_next != 2'd0) begin
      cp   = partial_point_next;
      done = 1'b1;
    end
    if (done || last) begin
      bytes_pending_next = 2'd0;
      partial_point_next = '0;
    end
  end

  assign push_entry.done = done;
  assign push_entry.cp   = cp;
  assign push_entry.last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_point <= '0;
    end else if (push) begin
      bytes_pending <= bytes_pending_next;
      partial_point <= partial_point_next;
    end
  end

endmodule

// File: rtl/utp_queue.sv
module utp_queue #(
  parameter int unsigned DEPTH = utp_pkg::QueueDepthDef
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  utp_pkg::entry_t  push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output utp_pkg::entry_t  head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  utp_pkg::entry_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/utp_back.sv
module utp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  utp_pkg::entry_t  head,
  output logic             pop,
  output logic             token_valid,
  input  logic             token_ready,
  output utp_pkg::token_t  token
);

  logic          inside_word;
  logic          inside_word_next;
  utp_pkg::cp_t  cp;
  logic          keep;
  logic          is_space;
  logic          is_cjk;
  logic          is_punct;
  utp_pkg::token_t result;

  assign pop = head_valid && (!token_valid || token_ready);

  always_comb begin
    cp = head.cp;
    if (cp >= 21'h41 && cp <= 21'h5A) begin
      cp = cp + 21'h20;
    end
    keep     = head.done && head.cp != '0 && head.cp != utp_pkg::Replacement;
    is_space = cp == 21'h20 || (cp >= 21'h09 && cp <= 21'h0D);
    is_cjk   = (cp >= 21'h04E00 && cp <= 21'h09FFF) ||
               (cp >= 21'h03400 && cp <= 21'h04DBF) ||
               (cp >= 21'h20000 && cp <= 21'h2A6DF) ||
               (cp >= 21'h2A700 && cp <= 21'h2CEAF) ||
               (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
               (cp >= 21'h2F800 && cp <= 21'h2FA1F) ||
               (cp >= 21'h03000 && cp <= 21'h0303F) ||
               (cp >= 21'h0FF00 && cp <= 21'h0FFEF);
    is_punct = (cp >= 21'd33 && cp <= 21'd47) || (cp >= 21'd58 && cp <= 21'd64) ||
               (cp >= 21'd91 && cp <= 21'd96) || (cp >= 21'd123 && cp <= 21'd126) ||
               (cp >= 21'h02000 && cp <= 21'h0206F);

    result.char_valid = 1'b0;
    result.code_point = '0;
    result.word_start = 1'b0;
    result.text_end   = head.last;
    inside_word_next  = inside_word;
    if (keep) begin
      if (is_space) begin
        inside_word_next = 1'b0;
      end else if (is_cjk || is_punct) begin
        result.char_valid = 1'b1;
        result.code_point = cp;
        result.word_start = 1'b1;
        inside_word_next  = 1'b0;
      end else begin
        result.char_valid = 1'b1;
        result.code_point = cp;
        result.word_start = !inside_word;
        inside_word_next  = 1'b1;
      end
    end
    // end of text closes any open word
    if (head.last) begin
      inside_word_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word <= 1'b0;
      token_valid <= 1'b0;
    end else begin
      if (pop) begin
        inside_word <= inside_word_next;
        token_valid <= 1'b1;
      end else if (token_ready) begin
        token_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      token <= result;
    end
  end

endmodule

// File: rtl/utf8_text_pretokenizer.sv
// UTF-8 text pretokenizer.
// Input channel text/text_valid/text_ready carries one byte of UTF-8 text a
// word, with last_byte set on the final byte of a text. Output channel
// token/token_valid/token_ready gives exactly one result word per input byte:
// char_valid and code_point when the byte completes a kept code point,
// word_start when that code point opens a new word, and text_end echoing
// last_byte.
// On its way to token_valid, an accepted byte enters the queue on its
// accepting edge, then the output register when empty or being taken.
// Throughput is one byte per cycle: the decoder takes a byte each cycle the
// queue has room, and the classifier drains one queue entry each cycle its
// output register is empty or being taken.
// Reset clears the decoder state, the queue, the open-word flag and the
// output valid flag; no clearing pass is needed and text_ready is high in the
// first cycle after reset.
// When the receiver holds token_ready low, the output word holds, the queue
// fills (QUEUE_DEPTH entries), then text_ready drops until the receiver
// resumes.
module utf8_text_pretokenizer #(
  parameter int unsigned QUEUE_DEPTH = utp_pkg::QueueDepthDef
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  output logic             text_ready,
  input  utp_pkg::text_t   text,
  output logic             token_valid,
  input  logic             token_ready,
  output utp_pkg::token_t  token
);

  logic            push;
  utp_pkg::entry_t push_entry;
  logic            queue_full;
  logic            pop;
  logic            head_valid;
  utp_pkg::entry_t head;

  utp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  utp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  utp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token       (token)
  );

endmodule
